// ===== src/rsos_pkg.sv =====
// shared types, register codes and the whole-degree sine table for the sweep segmenter
// no dependencies; used by every module of the block by scoped name
package rsos_pkg;

	// configuration register codes
	localparam logic [1:0] CFG_IR_THRESHOLD = 2'd0;
	localparam logic [1:0] CFG_MIN_RUN      = 2'd1;
	localparam logic [1:0] CFG_START_OFFSET = 2'd2;

	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 10;

	localparam logic [9:0] IR_THRESHOLD_RST = 10'd100;
	localparam logic [7:0] MIN_RUN_RST      = 8'd2;
	localparam logic [3:0] START_OFFSET_RST = 4'd2;

	localparam logic [63:0] PI_Q30 = 64'd3373259426;

	// one closed object, handed from the front to the back
	typedef struct packed {
		logic [3:0] number;
		logic [7:0] start;
		logic [7:0] length;
		logic [9:0] distance;
	} obj_event_t;

	typedef logic [15:0] sine_tab_t [0:90];

	// fixed point taylor series, Q30, evaluated at elaboration only
	function automatic logic [15:0] sine_deg_q15(input int unsigned deg);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] pos;
		logic [63:0] neg;
		logic [63:0] r;
		x = (64'(deg) * PI_Q30 + 64'd90) / 64'd180;
		x2 = (x * x) >> 30;
		term = x;
		pos = x;
		neg = 64'd0;
		term = ((term * x2) >> 30) / 64'd6;
		neg = neg + term;
		term = ((term * x2) >> 30) / 64'd20;
		pos = pos + term;
		term = ((term * x2) >> 30) / 64'd42;
		neg = neg + term;
		term = ((term * x2) >> 30) / 64'd72;
		pos = pos + term;
		term = ((term * x2) >> 30) / 64'd110;
		neg = neg + term;
		term = ((term * x2) >> 30) / 64'd156;
		pos = pos + term;
		term = ((term * x2) >> 30) / 64'd210;
		neg = neg + term;
		r = (pos >= neg) ? (pos - neg) : 64'd0;
		r = (r + 64'd16384) >> 15;
		if (r > 64'd32767) begin
			r = 64'd32767;
		end
		return r[15:0];
	endfunction

	function automatic sine_tab_t build_sine_tab();
		sine_tab_t t;
		for (int k = 0; k <= 90; k++) begin
			t[k] = sine_deg_q15(k);
		end
		return t;
	endfunction

	// sin(k deg) in Q1.15, k = 0..90
	localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

// ===== src/rsos_front.sv =====
// front end: configuration registers, run tracking and object open / close decisions
// depends on rsos_pkg
module rsos_front #(
	parameter int unsigned MAX_OBJECTS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic [rsos_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rsos_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           take,
	input  logic                           sweep_start,
	input  logic [7:0]                     angle,
	input  logic [9:0]                     ir_range,
	input  logic [9:0]                     sonar_range,
	output logic                           evt_push,
	output rsos_pkg::obj_event_t           evt
);

	localparam int unsigned SEEN_W = $clog2(MAX_OBJECTS + 1);

	logic [9:0]        ir_threshold_q;
	logic [7:0]        min_run_q;
	logic [3:0]        start_offset_q;
	logic [7:0]        run_q;
	logic              open_q;
	logic [7:0]        start_q;
	logic [9:0]        dist_q;
	logic [SEEN_W-1:0] seen_q;

	logic [7:0]        run0;
	logic              open0;
	logic [7:0]        start0;
	logic [9:0]        dist0;
	logic [SEEN_W-1:0] seen0;
	logic              opening;
	logic              open1;
	logic [7:0]        start1;
	logic [9:0]        dist1;
	logic [SEEN_W-1:0] seen1;
	logic [8:0]        start_sum;
	logic              in_view;
	logic [4:0]        number_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ir_threshold_q <= rsos_pkg::IR_THRESHOLD_RST;
			min_run_q      <= rsos_pkg::MIN_RUN_RST;
			start_offset_q <= rsos_pkg::START_OFFSET_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				rsos_pkg::CFG_IR_THRESHOLD: ir_threshold_q <= cfg_data[9:0];
				rsos_pkg::CFG_MIN_RUN:      min_run_q      <= cfg_data[7:0];
				rsos_pkg::CFG_START_OFFSET: start_offset_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		// sweep start wipes the sweep state before the sample is looked at
		run0   = sweep_start ? 8'd0 : run_q;
		open0  = sweep_start ? 1'b0 : open_q;
		start0 = sweep_start ? 8'd0 : start_q;
		dist0  = sweep_start ? 10'd0 : dist_q;
		seen0  = sweep_start ? '0 : seen_q;

		opening   = !open0 && (run0 > min_run_q) && (32'(seen0) < MAX_OBJECTS);
		start_sum = {1'b0, angle} + {5'd0, start_offset_q};
		open1  = open0 | opening;
		start1 = opening ? (start_sum[8] ? 8'hFF : start_sum[7:0]) : start0;
		dist1  = opening ? sonar_range : dist0;
		seen1  = opening ? seen0 + SEEN_W'(1) : seen0;

		in_view    = ir_range < ir_threshold_q;
		number_ext = 5'(seen1) - 5'd1;

		evt_push     = take && !in_view && open1;
		evt.number   = number_ext[3:0];
		evt.start    = start1;
		evt.length   = run0;
		evt.distance = dist1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 8'd0;
			open_q  <= 1'b0;
			start_q <= 8'd0;
			dist_q  <= 10'd0;
			seen_q  <= '0;
		end else if (take) begin
			start_q <= start1;
			seen_q  <= seen1;
			if (in_view) begin
				run_q  <= (run0 == 8'hFF) ? run0 : run0 + 8'd1;
				open_q <= open1;
				dist_q <= open1 ? sonar_range : dist1;
			end else begin
				run_q  <= 8'd0;
				open_q <= 1'b0;
				dist_q <= dist1;
			end
		end
	end

endmodule

// ===== src/rsos_queue.sv =====
// short first-in first-out queue of closed objects between front and back
// depends on rsos_pkg
module rsos_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  rsos_pkg::obj_event_t wr_data,
	input  logic                 pop,
	output rsos_pkg::obj_event_t rd_data,
	output logic                 full,
	output logic                 empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	rsos_pkg::obj_event_t slot_q [0:DEPTH-1];
	logic [PTR_W-1:0]     wr_ptr_q;
	logic [PTR_W-1:0]     rd_ptr_q;
	logic [CNT_W-1:0]     count_q;

	assign full    = (32'(count_q) == DEPTH);
	assign empty   = (count_q == '0);
	assign rd_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (32'(wr_ptr_q) == DEPTH - 1) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == DEPTH - 1) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== src/rsos_back.sv =====
// back end: end angle and half-angle sine, then width multiply; the last stage is the result
// depends on rsos_pkg (event type, sine table)
module rsos_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 evt_valid,
	input  rsos_pkg::obj_event_t evt,
	output logic                 evt_take,
	input  logic                 pop,
	output logic                 empty,
	output logic [3:0]           object_number,
	output logic [7:0]           start_angle,
	output logic [7:0]           end_angle,
	output logic [9:0]           object_distance,
	output logic [12:0]          object_width
);

	logic        v_s1;
	logic [3:0]  number_s1;
	logic [7:0]  start_s1;
	logic [7:0]  end_s1;
	logic [9:0]  dist_s1;
	logic [15:0] sine_s1;

	logic        v_s2;
	logic [3:0]  number_s2;
	logic [7:0]  start_s2;
	logic [7:0]  end_s2;
	logic [9:0]  dist_s2;
	logic [12:0] width_s2;

	logic        adv_s2;
	logic        adv_s1;
	logic [8:0]  fold;
	logic [6:0]  idx0;
	logic [6:0]  idx1;
	logic [16:0] pair_sum;
	logic [15:0] sine_c;
	logic [9:0]  end_wide;
	logic [7:0]  end_c;
	logic [25:0] product;
	logic [13:0] width_raw;

	assign adv_s2   = !v_s2 || pop;
	assign adv_s1   = !v_s1 || adv_s2;
	assign evt_take = evt_valid && adv_s1;

	always_comb begin
		// lengths past 180 fold back by symmetry
		fold     = (evt.length > 8'd180) ? (9'd360 - {1'b0, evt.length}) : {1'b0, evt.length};
		idx0     = fold[7:1];
		idx1     = (idx0 == 7'd90) ? idx0 : idx0 + 7'd1;
		pair_sum = {1'b0, rsos_pkg::SINE_TAB[idx0]} + {1'b0, rsos_pkg::SINE_TAB[idx1]} + 17'd1;
		sine_c   = fold[0] ? pair_sum[16:1] : rsos_pkg::SINE_TAB[idx0];

		end_wide = {2'b00, evt.start} - {2'b00, evt.length} + 10'd1;
		if (end_wide[9]) begin
			end_c = 8'd0;
		end else if (end_wide[8]) begin
			end_c = 8'hFF;
		end else begin
			end_c = end_wide[7:0];
		end

		product   = {16'd0, dist_s1} * {10'd0, sine_s1};
		width_raw = 14'((product + 26'd2048) >> 12);
	end

	always_ff @(posedge clk) begin
		if (evt_take) begin
			number_s1 <= evt.number;
			start_s1  <= evt.start;
			end_s1    <= end_c;
			dist_s1   <= evt.distance;
			sine_s1   <= sine_c;
		end
		if (adv_s2 && v_s1) begin
			number_s2 <= number_s1;
			start_s2  <= start_s1;
			end_s2    <= end_s1;
			dist_s2   <= dist_s1;
			width_s2  <= width_raw[13] ? 13'h1FFF : width_raw[12:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				v_s1 <= evt_valid;
			end
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	assign empty           = !v_s2;
	assign object_number   = number_s2;
	assign start_angle     = start_s2;
	assign end_angle       = end_s2;
	assign object_distance = dist_s2;
	assign object_width    = width_s2;

endmodule

// ===== src/range_sweep_object_segmenter_core.sv =====
// top level of the range sweep object segmenter: front, object queue and width back end
// depends on rsos_pkg, rsos_front, rsos_queue, rsos_back
//
// usage
//   sample channel: drive sweep_start, angle, ir_range, sonar_range and raise push;
//   a sample transfer happens on a rising edge with push high and full low
//   result channel: while empty is low the oldest closed object sits on the result
//   ports; raise pop to take it, the transfer happens on an edge with pop high
//   and empty low
//   config channel: cfg_valid with cfg_index / cfg_data; cfg_ready is always high,
//   so every write takes effect on its edge; indexes past the list are dropped
// throughput: one sample per cycle while full is low, the front decides open / close in a single step
// path: a closing sample's record passes the queue, the sine lookup stage and the
//   width multiply stage before it shows on the result ports
// stall: while pop is held low the back end stops, the object queue absorbs up to
//   QUEUE_DEPTH closed objects; full rises only when that queue has no room
// reset: registers return to ir_threshold 100, min_run 2, start_offset 2; run,
//   open object and object count clear; queue and result stages empty
module range_sweep_object_segmenter_core #(
	parameter int unsigned MAX_OBJECTS = 16,
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rsos_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rsos_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            push,
	output logic                            full,
	input  logic                            sweep_start,
	input  logic [7:0]                      angle,
	input  logic [9:0]                      ir_range,
	input  logic [9:0]                      sonar_range,
	output logic                            empty,
	input  logic                            pop,
	output logic [3:0]                      object_number,
	output logic [7:0]                      start_angle,
	output logic [7:0]                      end_angle,
	output logic [9:0]                      object_distance,
	output logic [12:0]                     object_width
);

	logic                 take;
	logic                 q_push;
	logic                 q_pop;
	logic                 q_full;
	logic                 q_empty;
	rsos_pkg::obj_event_t front_evt;
	rsos_pkg::obj_event_t q_head;

	// config writes never wait
	assign cfg_ready = 1'b1;

	// the front only waits on room in the object queue
	assign full = q_full;
	assign take = push && !q_full;

	rsos_front #(
		.MAX_OBJECTS(MAX_OBJECTS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.take       (take),
		.sweep_start(sweep_start),
		.angle      (angle),
		.ir_range   (ir_range),
		.sonar_range(sonar_range),
		.evt_push   (q_push),
		.evt        (front_evt)
	);

	rsos_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_data(front_evt),
		.pop    (q_pop),
		.rd_data(q_head),
		.full   (q_full),
		.empty  (q_empty)
	);

	rsos_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.evt_valid      (!q_empty),
		.evt            (q_head),
		.evt_take       (q_pop),
		.pop            (pop),
		.empty          (empty),
		.object_number  (object_number),
		.start_angle    (start_angle),
		.end_angle      (end_angle),
		.object_distance(object_distance),
		.object_width   (object_width)
	);

`ifndef SYNTHESIS
	// a close event never lands on a full queue
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("object queue overflow");

	// back end only drains a queue that holds something
	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("object queue underflow");

	// end angle can never pass start angle plus one
	a_end_not_past_start: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> ({1'b0, end_angle} <= ({1'b0, start_angle} + 9'd1)))
		else $error("end angle beyond start angle");

	// zero distance gives zero width
	a_zero_dist_zero_width: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && object_distance == 10'd0) |-> (object_width == 13'd0))
		else $error("width without distance");
`endif

endmodule
